@@ rtl/core/gbn_pkg.sv @@
// gbn_pkg: shared types, codes and constants of the go-back-n sender
// no dependencies; imported by gbn_ctrl, gbn_dp, go_back_n_sender, gbn_checker and testbench
`timescale 1ns / 1ps

package gbn_pkg;

   localparam int SEQ_BITS      = 16;
   localparam int NUM_BITS      = SEQ_BITS + 1;
   localparam int TOP_BITS      = NUM_BITS + 1;
   localparam int TIME_BITS     = 28;
   localparam int RTT_BITS      = 24;
   localparam int WS_BITS       = 6;
   localparam int TOT_BITS      = 16;
   localparam int TRY_BITS      = 4;
   localparam int OP_BITS       = 2;
   localparam int KIND_BITS     = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [OP_BITS-1:0] OP_START = 2'd0;
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ACK   = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIES  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RTT    = 2'd3;

   localparam logic [WS_BITS-1:0]   WS_RESET    = 6'd4;
   localparam logic [TOT_BITS-1:0]  TOT_RESET   = 16'd1;
   localparam logic [TRY_BITS-1:0]  TRIES_RESET = 4'd3;
   localparam logic [RTT_BITS-1:0]  RTT_RESET   = 24'd500000;
   localparam logic [TIME_BITS-1:0] ELAPSED_MAX = 28'hFFFFFFF;

   typedef enum logic [KIND_BITS-1:0] {
      K_INIT = 2'd0,
      K_DATA = 2'd1,
      K_DONE = 2'd2,
      K_FAIL = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_INIT,
      PH_XFER,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TOUT,
      ST_EMIT,
      ST_WIN
   } state_type;

   typedef struct packed {
      logic     take;
      logic     timer_clear;
      logic     seq_init;
      logic     slide;
      logic     rewind;
      logic     tick;
      logic     load_limit;
      logic     advance;
      logic     load_out;
      kind_type out_kind;
      logic     out_last;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               timeout;
      logic               tries_out;
      logic               ack_one;
      logic               ack_done;
      logic               win_ok;
      logic               win_more;
      logic               out_free;
   } status_type;

endpackage

@@ rtl/core/gbn_ctrl.sv @@
// gbn_ctrl: sequencer and transfer phase of the go-back-n sender
// depends on gbn_pkg; drives gbn_dp through cmd_type, reads status_type
`timescale 1ns / 1ps

module gbn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gbn_pkg::status_type status,
   output gbn_pkg::cmd_type    cmd
);
   import gbn_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   kind_type  kind_ff, kind_in;

   logic live;

   assign live = (phase_ff == PH_INIT) || (phase_ff == PH_XFER);

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (status.op)
               OP_START: begin
                  phase_in = PH_INIT;
                  kind_in  = K_INIT;
                  state_in = ST_EMIT;
               end
               OP_TICK: begin
                  if (live && status.timeout) state_in = ST_TOUT;
               end
               OP_ACK: begin
                  if (phase_ff == PH_INIT) begin
                     if (status.ack_one) begin
                        phase_in = PH_XFER;
                        state_in = ST_WIN;
                     end else begin
                        phase_in = PH_FAIL;
                        kind_in  = K_FAIL;
                        state_in = ST_EMIT;
                     end
                  end else if (phase_ff == PH_XFER) begin
                     if (status.ack_done) begin
                        phase_in = PH_DONE;
                        kind_in  = K_DONE;
                        state_in = ST_EMIT;
                     end else begin
                        state_in = ST_WIN;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_TOUT: begin
            if (status.tries_out) begin
               phase_in = PH_FAIL;
               kind_in  = K_FAIL;
               state_in = ST_EMIT;
            end else if (phase_ff == PH_INIT) begin
               kind_in  = K_INIT;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_WIN;
            end
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_WIN: begin
            if (!status.win_ok) state_in = ST_IDLE;
            else if (status.out_free && !status.win_more) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      cmd.take   = (state_ff == ST_IDLE) && req_tvalid;
      unique case (state_ff)
         ST_IDLE: ;
         ST_EXEC: begin
            unique case (status.op)
               OP_START: begin
                  cmd.seq_init    = 1'b1;
                  cmd.timer_clear = 1'b1;
               end
               OP_TICK: begin
                  cmd.tick = live;
               end
               OP_ACK: begin
                  if (phase_ff == PH_INIT && status.ack_one) begin
                     cmd.seq_init    = 1'b1;
                     cmd.timer_clear = 1'b1;
                  end else if (phase_ff == PH_XFER && !status.ack_done) begin
                     cmd.slide       = 1'b1;
                     cmd.timer_clear = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_TOUT: begin
            if (!status.tries_out) begin
               cmd.load_limit = 1'b1;
               cmd.rewind     = (phase_ff == PH_XFER);
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = kind_ff;
               cmd.out_last = 1'b1;
            end
         end
         ST_WIN: begin
            if (status.win_ok && status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = K_DATA;
               cmd.out_last = !status.win_more;
               cmd.advance  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         kind_ff  <= K_INIT;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_EXEC)
      else $error("accepted item not executed");

   a_data_in_xfer: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && cmd.out_kind == K_DATA) |-> phase_ff == PH_XFER)
      else $error("data command outside transfer phase");

   a_win_in_xfer: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WIN |-> phase_ff == PH_XFER)
      else $error("window issue outside transfer phase");

endmodule

@@ rtl/core/gbn_dp.sv @@
// gbn_dp: config registers, sequence and timer datapath, result register
// depends on gbn_pkg; commanded by gbn_ctrl
`timescale 1ns / 1ps

module gbn_dp #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gbn_pkg::cmd_type                    cmd,
   output gbn_pkg::status_type                 status,
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [gbn_pkg::OP_BITS-1:0]         req_tuser,
   input  logic                                csr_we,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gbn_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [gbn_pkg::KIND_BITS-1:0]       rsp_tuser,
   output logic                                rsp_tlast
);
   import gbn_pkg::*;

   localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
   localparam int WC_BITS  = (CNT_BITS > WS_BITS) ? CNT_BITS : WS_BITS;
   localparam logic [WC_BITS-1:0]  W_LIMIT  = WC_BITS'(WINDOW_MAX);
   localparam logic [CNT_BITS-1:0] CNT_MAX  = CNT_BITS'(WINDOW_MAX);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WINDOW_MAX - 1);

   logic [WS_BITS-1:0]   ws_ff, ws_in;
   logic [TOT_BITS-1:0]  total_ff, total_in;
   logic [TRY_BITS-1:0]  tries_ff, tries_in;
   logic [RTT_BITS-1:0]  rtt_ff, rtt_in;

   logic [OP_BITS-1:0]   op_ff;
   logic [NUM_BITS-1:0]  ack_ff;

   logic [NUM_BITS-1:0]  base_ff, base_in;
   logic [NUM_BITS-1:0]  nts_ff, nts_in;
   logic [TRY_BITS-1:0]  att_ff, att_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0] limit_ff, limit_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   logic                 valid_ff, valid_in;
   kind_type             kind_ff;
   logic [SEQ_BITS-1:0]  seq_ff;
   logic                 last_ff;

   logic [TIME_BITS-1:0] elapsed_inc;
   logic [NUM_BITS-1:0]  slid_base;
   logic [NUM_BITS-1:0]  total_ext;
   logic [WC_BITS-1:0]   ws_ext;
   logic [WC_BITS-1:0]   w_clamp;
   logic [TOP_BITS-1:0]  top;

   assign total_ext   = NUM_BITS'(total_ff);
   assign ws_ext      = WC_BITS'(ws_ff);
   assign w_clamp     = (ws_ff == '0) ? WC_BITS'(1) :
                        (ws_ext > W_LIMIT) ? W_LIMIT : ws_ext;
   assign top         = TOP_BITS'(base_ff) + TOP_BITS'(w_clamp) - TOP_BITS'(1);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff
                                                    : elapsed_ff + TIME_BITS'(1);
   assign slid_base   = (ack_ff > base_ff) ? ack_ff : base_ff;

   always_comb begin
      status           = '0;
      status.op        = op_ff;
      status.timeout   = (elapsed_inc >= limit_ff);
      status.tries_out = (att_ff >= tries_ff);
      status.ack_one   = (ack_ff == NUM_BITS'(1));
      status.ack_done  = (ack_ff == total_ext + NUM_BITS'(1));
      status.win_ok    = (TOP_BITS'(nts_ff) <= top) && (nts_ff <= total_ext)
                         && (cnt_ff < CNT_MAX);
      status.win_more  = (TOP_BITS'(nts_ff) < top) && (nts_ff < total_ext)
                         && (cnt_ff < CNT_LAST);
      status.out_free  = !valid_ff || rsp_tready;
   end

   // config writes
   always_comb begin
      ws_in    = ws_ff;
      total_in = total_ff;
      tries_in = tries_ff;
      rtt_in   = rtt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW: ws_in    = csr_wdata[WS_BITS-1:0];
            CSR_TOTAL:  total_in = csr_wdata[TOT_BITS-1:0];
            CSR_TRIES:  tries_in = csr_wdata[TRY_BITS-1:0];
            CSR_RTT:    rtt_in   = csr_wdata[RTT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequence numbers and timer
   always_comb begin
      base_in    = base_ff;
      nts_in     = nts_ff;
      att_in     = att_ff;
      elapsed_in = elapsed_ff;
      limit_in   = limit_ff;
      cnt_in     = cnt_ff;
      if (cmd.seq_init) begin
         base_in = NUM_BITS'(1);
         nts_in  = NUM_BITS'(1);
         cnt_in  = '0;
      end
      if (cmd.slide) begin
         base_in = slid_base;
         nts_in  = (nts_ff < slid_base) ? slid_base : nts_ff;
         cnt_in  = '0;
      end
      if (cmd.rewind) begin
         nts_in = base_ff;
         cnt_in = '0;
      end
      if (cmd.advance) begin
         nts_in = nts_ff + NUM_BITS'(1);
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
      if (cmd.timer_clear) begin
         att_in     = '0;
         elapsed_in = '0;
         limit_in   = TIME_BITS'(rtt_ff);
      end
      if (cmd.tick) begin
         if (status.timeout) begin
            elapsed_in = '0;
            att_in     = att_ff + TRY_BITS'(1);
         end else begin
            elapsed_in = elapsed_inc;
         end
      end
      if (cmd.load_limit) begin
         limit_in = (TIME_BITS'(att_ff) + TIME_BITS'(1)) * TIME_BITS'(rtt_ff);
      end
   end

   // result register
   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff      <= WS_RESET;
         total_ff   <= TOT_RESET;
         tries_ff   <= TRIES_RESET;
         rtt_ff     <= RTT_RESET;
         base_ff    <= NUM_BITS'(1);
         nts_ff     <= NUM_BITS'(1);
         att_ff     <= '0;
         elapsed_ff <= '0;
         limit_ff   <= TIME_BITS'(RTT_RESET);
         cnt_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         ws_ff      <= ws_in;
         total_ff   <= total_in;
         tries_ff   <= tries_in;
         rtt_ff     <= rtt_in;
         base_ff    <= base_in;
         nts_ff     <= nts_in;
         att_ff     <= att_in;
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         cnt_ff     <= cnt_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_tuser;
         ack_ff <= req_tdata[NUM_BITS-1:0];
      end
      if (cmd.load_out) begin
         kind_ff <= cmd.out_kind;
         seq_ff  <= (cmd.out_kind == K_DATA) ? nts_ff[SEQ_BITS-1:0] : '0;
         last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(seq_ff);
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_slide_order: assert property (@(posedge clock) disable iff (reset)
      cmd.slide |=> nts_ff >= base_ff)
      else $error("next sequence below window base after slide");

   a_limit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_limit && rtt_ff != '0) |=> limit_ff != '0)
      else $error("retry timeout loaded as zero");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

@@ rtl/core/go_back_n_sender.sv @@
// go_back_n_sender: go-back-n arq sender control, top level; uses gbn_pkg, gbn_ctrl, gbn_dp
// an item goes through the exec state, and the timeout state on a timeout, before its first
// result, then one result per cycle from the result register while the receiver is ready;
// the single sequence counter issues one slot per cycle unless the output stalls; one item in flight
// synchronous active-high reset loads the register defaults and an idle transfer
`timescale 1ns / 1ps

module go_back_n_sender #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // ack_num
   input  logic [gbn_pkg::OP_BITS-1:0]         req_tuser,  // op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gbn_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // seq
   output logic [gbn_pkg::KIND_BITS-1:0]       rsp_tuser,  // kind
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import gbn_pkg::*;

   cmd_type    cmd;
   status_type status;

   gbn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gbn_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ sim/gbn_checker.sv @@
// gbn_checker: watches the request, result and register ports of the go-back-n sender,
// predicts the send commands of each request and compares them field by field
// depends on gbn_pkg for widths, op and register codes, kinds and phases
`timescale 1ns / 1ps

module gbn_checker #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // ack_num
   input  logic [gbn_pkg::OP_BITS-1:0]        req_tuser,  // op
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [gbn_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // seq
   input  logic [gbn_pkg::KIND_BITS-1:0]      rsp_tuser,  // kind
   input  logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 mismatches,
   output int                                 pending,
   output int                                 compared
);
   import gbn_pkg::*;

   typedef struct packed {
      kind_type            kind;
      logic [SEQ_BITS-1:0] seq;
      logic                last;
   } send_cmd_type;

   send_cmd_type         send_cmd_q[$];

   logic [WS_BITS-1:0]   cfg_window;
   logic [TOT_BITS-1:0]  cfg_total;
   logic [TRY_BITS-1:0]  cfg_tries;
   logic [RTT_BITS-1:0]  cfg_rtt;

   phase_type            phase;
   logic [NUM_BITS-1:0]  base_seq;
   logic [NUM_BITS-1:0]  next_seq;
   logic [TRY_BITS-1:0]  tries_used;
   logic [TIME_BITS-1:0] ticks;
   logic [TIME_BITS-1:0] ticks_limit;
   int                   step_cmds;

   task automatic report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: %s mismatch at result %0d: expected %0d, got %0d",
                  $time, field, compared, want, got);
   endtask

   function automatic void push_cmd(kind_type kind, logic [NUM_BITS-1:0] seq);
      send_cmd_type cmd;
      cmd.kind = kind;
      cmd.seq  = seq[SEQ_BITS-1:0];
      cmd.last = 1'b0;
      send_cmd_q.push_back(cmd);
      step_cmds++;
   endfunction

   function automatic void restart_timer();
      tries_used  = '0;
      ticks       = '0;
      ticks_limit = cfg_rtt;
   endfunction

   // issue every open slot of the window, one data command each
   function automatic void issue_window();
      int unsigned span;
      int unsigned top_seq;
      span = cfg_window;
      if (span < 1) span = 1;
      if (span > WINDOW_MAX) span = WINDOW_MAX;
      top_seq = base_seq + span - 1;
      while (step_cmds < WINDOW_MAX && next_seq <= cfg_total && next_seq <= top_seq) begin
         push_cmd(K_DATA, next_seq);
         next_seq = next_seq + 1'b1;
      end
   endfunction

   function automatic void sender_step(logic [OP_BITS-1:0] op, logic [NUM_BITS-1:0] ack);
      send_cmd_type tail;
      step_cmds = 0;
      case (op)
         OP_START: begin
            phase    = PH_INIT;
            base_seq = 1;
            next_seq = 1;
            restart_timer();
            push_cmd(K_INIT, '0);
         end
         OP_TICK: begin
            if (phase == PH_INIT || phase == PH_XFER) begin
               if (ticks < ELAPSED_MAX) ticks = ticks + 1'b1;
               if (ticks >= ticks_limit) begin
                  ticks      = '0;
                  tries_used = tries_used + 1'b1;
                  if (tries_used >= cfg_tries) begin
                     phase = PH_FAIL;
                     push_cmd(K_FAIL, '0);
                  end else begin
                     ticks_limit = (tries_used + 32'd1) * cfg_rtt;
                     if (phase == PH_INIT) begin
                        push_cmd(K_INIT, '0);
                     end else begin
                        next_seq = base_seq;
                        issue_window();
                     end
                  end
               end
            end
         end
         OP_ACK: begin
            if (phase == PH_INIT) begin
               if (ack == 1) begin
                  phase    = PH_XFER;
                  base_seq = 1;
                  next_seq = 1;
                  restart_timer();
                  issue_window();
               end else begin
                  phase = PH_FAIL;
                  push_cmd(K_FAIL, '0);
               end
            end else if (phase == PH_XFER) begin
               if (ack == cfg_total + 32'd1) begin
                  phase = PH_DONE;
                  push_cmd(K_DONE, '0);
               end else begin
                  if (ack > base_seq) base_seq = ack;
                  if (next_seq < base_seq) next_seq = base_seq;
                  restart_timer();
                  issue_window();
               end
            end
         end
         default: ;
      endcase
      if (step_cmds > 0) begin
         tail = send_cmd_q.pop_back();
         tail.last = 1'b1;
         send_cmd_q.push_back(tail);
      end
   endfunction

   task automatic check_result();
      send_cmd_type want;
      if (send_cmd_q.size() == 0) begin
         report("unexpected transfer, kind", '0, rsp_tuser);
      end else begin
         want = send_cmd_q.pop_front();
         if (rsp_tuser !== want.kind) report("kind", want.kind, rsp_tuser);
         if (rsp_tdata !== want.seq) report("seq", want.seq, rsp_tdata);
         if (rsp_tlast !== want.last) report("last", want.last, rsp_tlast);
         compared++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_window = WS_RESET;
         cfg_total  = TOT_RESET;
         cfg_tries  = TRIES_RESET;
         cfg_rtt    = RTT_RESET;
         phase      = PH_IDLE;
         base_seq   = 1;
         next_seq   = 1;
         restart_timer();
         send_cmd_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW: cfg_window = csr_wdata[WS_BITS-1:0];
               CSR_TOTAL:  cfg_total  = csr_wdata[TOT_BITS-1:0];
               CSR_TRIES:  cfg_tries  = csr_wdata[TRY_BITS-1:0];
               CSR_RTT:    cfg_rtt    = csr_wdata[RTT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) sender_step(req_tuser, req_tdata[NUM_BITS-1:0]);
      end
      pending = send_cmd_q.size();
   end

endmodule

@@ sim/testbench.sv @@
// testbench: drives requests, register writes and result back-pressure into the
// go-back-n sender; gbn_checker predicts and compares; depends on gbn_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
   import gbn_pkg::*;

   localparam int WINDOW_MAX    = 32;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int SESSIONS      = 4;
   localparam int SESSION_ITEMS = 12;
   localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata;  // ack_num
   logic [OP_BITS-1:0]         req_tuser;  // op
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;  // seq
   logic [KIND_BITS-1:0]       rsp_tuser;  // kind
   logic                       rsp_tlast;
   logic                       csr_we;
   logic [CSR_IDX_BITS-1:0]    csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   int                         mismatches;
   int                         pending;
   int                         compared;
   int                         items_sent;
   int                         settings_used;
   int unsigned                cycles;
   logic                       quiet_tx;
   logic                       quiet_rx;
   logic                       hold_req;

   go_back_n_sender #(.WINDOW_MAX(WINDOW_MAX)) u_dut (.*);

   gbn_checker #(.WINDOW_MAX(WINDOW_MAX)) u_checker (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d transfers outstanding", cycles, pending);
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_op(logic [OP_BITS-1:0] op, logic [NUM_BITS-1:0] ack);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_BITS-NUM_BITS){1'b0}}, ack};
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [WS_BITS-1:0] ws, logic [TOT_BITS-1:0] tot,
                            logic [TRY_BITS-1:0] tries, logic [RTT_BITS-1:0] rtt);
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW;
      csr_wdata <= ws;
      @(posedge clock);
      csr_index <= CSR_TOTAL;
      csr_wdata <= tot;
      @(posedge clock);
      csr_index <= CSR_TRIES;
      csr_wdata <= tries;
      @(posedge clock);
      csr_index <= CSR_RTT;
      csr_wdata <= rtt;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // mostly in-order acks with random advance, plus ticks, stale acks and noise
   task automatic random_session(int count, int unsigned span, int unsigned total);
      int unsigned acked;
      int unsigned ack;
      int unsigned pick;
      bit          opened;
      send_op(OP_START, $urandom_range(0, 17'h1FFFF));
      acked  = 1;
      opened = 1'b0;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if (!opened) begin
               ack    = 1;
               opened = 1'b1;
            end else begin
               ack = acked + $urandom_range(0, span);
               if (ack > total + 1) ack = total + 1;
               acked = ack;
            end
            send_op(OP_ACK, ack);
            if (ack == total + 1) begin
               send_op(OP_START, $urandom_range(0, 17'h1FFFF));
               acked  = 1;
               opened = 1'b0;
            end
         end else if (pick < 80) begin
            send_op(OP_TICK, $urandom_range(0, 17'h1FFFF));
         end else if (pick < 88) begin
            send_op(OP_ACK, (acked > 2) ? acked - $urandom_range(1, 2) : 0);
         end else if (pick < 93) begin
            send_op(OP_ACK, $urandom_range(0, 17'h1FFFF));
         end else if (pick < 96) begin
            send_op(OP_SPARE, $urandom_range(0, 17'h1FFFF));
         end else begin
            send_op(OP_START, $urandom_range(0, 17'h1FFFF));
            acked  = 1;
            opened = 1'b0;
         end
      end
   endtask

   initial begin : receiver
      int stall;
      int held;
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            hold_done  = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end else begin
            stall = quiet_rx ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   initial begin : stimulus
      int          k;
      int unsigned ws;
      int unsigned span;
      int unsigned tot;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_TICK;
      csr_we        = 1'b0;
      csr_index     = CSR_WINDOW;
      csr_wdata     = '0;
      quiet_tx      = 1'b0;
      quiet_rx      = 1'b0;
      hold_req      = 1'b0;
      items_sent    = 0;
      settings_used = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // register defaults: ignored items while idle, then a one-packet transfer
      send_op(OP_TICK, 17'h1FFFF);
      send_op(OP_ACK, 1);
      send_op(OP_START, 0);
      send_op(OP_ACK, 1);
      send_op(OP_ACK, 2);
      send_op(OP_TICK, 0);
      settle();

      // window of zero, init retry, stale ack, rewind and failure on timeouts
      configure(6'd0, 16'd3, 4'd2, 24'd1);
      send_op(OP_START, 0);
      send_op(OP_TICK, 0);
      send_op(OP_ACK, 1);
      send_op(OP_ACK, 1);
      send_op(OP_TICK, 0);
      send_op(OP_TICK, 0);
      send_op(OP_TICK, 0);
      send_op(OP_ACK, 3);
      settle();

      // full-scale registers, oversized window, restart mid transfer, ack past sent
      configure(6'd63, 16'hFFFF, 4'd15, 24'hFFFFFF);
      send_op(OP_START, 0);
      send_op(OP_ACK, 1);
      send_op(OP_ACK, 40);
      send_op(OP_START, 0);
      send_op(OP_ACK, 1);
      send_op(OP_ACK, 17'h1FFFF);
      send_op(OP_ACK, 17'h10000);
      send_op(OP_START, 0);
      send_op(OP_ACK, 0);
      settle();

      // zero total, tries and rtt registers: instant failure, empty window, spare op code
      configure(6'd1, 16'd0, 4'd0, 24'd0);
      send_op(OP_START, 0);
      send_op(OP_TICK, 0);
      send_op(OP_START, 0);
      send_op(OP_ACK, 1);
      send_op(OP_ACK, 1);
      send_op(OP_SPARE, 17'h1FFFF);
      settle();

      // receiver holds off while acks keep opening slots
      configure(6'd32, 16'd300, 4'd3, 24'd5000);
      send_op(OP_START, 0);
      send_op(OP_ACK, 1);
      hold_req <= 1'b1;
      quiet_tx = 1'b1;
      for (k = 2; k <= 25; k++) send_op(OP_ACK, k);
      quiet_tx = 1'b0;
      send_op(OP_ACK, 301);
      settle();

      for (k = 0; k < SESSIONS; k++) begin
         case ($urandom_range(0, 9))
            0:       ws = 0;
            1:       ws = 63;
            2:       ws = 32;
            default: ws = $urandom_range(1, 8);
         endcase
         span = (ws < 1) ? 1 : (ws > WINDOW_MAX) ? WINDOW_MAX : ws;
         tot  = $urandom_range(1, 20);
         quiet_tx = ($urandom_range(0, 3) == 0);
         quiet_rx = ($urandom_range(0, 3) == 0);
         configure(ws, tot, $urandom_range(1, 4), $urandom_range(1, 6));
         random_session(SESSION_ITEMS, span, tot);
         settle();
      end

      $display("covered %0d requests under %0d register settings, %0d send commands compared",
               items_sent, settings_used, compared);
      $display("incl. clamped windows, zero and full-scale registers, timeouts, failures,");
      $display("and a %0d-cycle receiver stall", HOLD_CYCLES);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/gbn_pkg.sv
rtl/core/gbn_ctrl.sv
rtl/core/gbn_dp.sv
rtl/core/go_back_n_sender.sv
sim/gbn_checker.sv
sim/testbench.sv
